// ===== rtl/core/sign_magnitude_mul_div_unit_macros.svh =====
// Assertion macros for the sign-magnitude multiply/divide unit.
// Expects signals clk and arst_n in the scope of each use.
// Define ASSERT_OFF to compile every assertion out.
`ifndef SIGN_MAGNITUDE_MUL_DIV_UNIT_MACROS_SVH
`define SIGN_MAGNITUDE_MUL_DIV_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge out of reset
`define SMMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// post must hold in the cycle after pre
`define SMMD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SMMD_ASSERT(lbl, prop, msg)
`define SMMD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/core/smmd_pkg.sv =====
// Shared types for the sign-magnitude multiply/divide unit.
// No dependencies.
`timescale 1ns / 1ps

package smmd_pkg;

	// operation codes
	typedef enum logic {
		CMD_MUL = 1'b0,
		CMD_DIV = 1'b1
	} cmd_t;

	// control that travels with each item through the pipeline
	typedef struct packed {
		cmd_t cmd;
		logic sign;
	} ctrl_t;

endpackage

// ===== rtl/core/smmd_if.sv =====
// Valid/ready channel interfaces for the operand and result sides.
// No dependencies.
`timescale 1ns / 1ps

interface smmd_op_if #(
	parameter int WORD_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [WORD_BITS-1:0] operand_a;
	logic [WORD_BITS-1:0] operand_b;

	modport source (output valid, command, operand_a, operand_b, input ready);
	modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface smmd_res_if #(
	parameter int WORD_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic                 result_sign;
	logic [WORD_BITS-1:0] result_bits;

	modport source (output valid, result_sign, result_bits, input ready);
	modport sink   (input valid, result_sign, result_bits, output ready);
endinterface

// ===== rtl/core/smmd_stage.sv =====
// One pipeline stage: one shift-add multiply step or one restoring divide step.
// Depends on smmd_pkg.
`timescale 1ns / 1ps

module smmd_stage
	import smmd_pkg::*;
#(
	parameter int WORD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  ctrl_t                  up_ctrl,
	input  logic [WORD_BITS-2:0]   up_acc,
	input  logic [WORD_BITS-2:0]   up_mcand,
	input  logic [WORD_BITS-2:0]   up_mplier,
	input  logic [WORD_BITS-1:0]   up_quot,
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output ctrl_t                  dn_ctrl,
	output logic [WORD_BITS-2:0]   dn_acc,
	output logic [WORD_BITS-2:0]   dn_mcand,
	output logic [WORD_BITS-2:0]   dn_mplier,
	output logic [WORD_BITS-1:0]   dn_quot
);

	localparam int MAG_BITS = WORD_BITS - 1;

	logic                valid_s1;
	ctrl_t               ctrl_s1;
	logic [MAG_BITS-1:0] acc_s1;
	logic [MAG_BITS-1:0] mcand_s1;
	logic [MAG_BITS-1:0] mplier_s1;
	logic [WORD_BITS-1:0] quot_s1;

	logic                ge;
	logic [MAG_BITS-1:0] diff;
	logic [MAG_BITS-1:0] rem;
	logic [MAG_BITS-1:0] acc_n;
	logic [MAG_BITS-1:0] mcand_n;
	logic [MAG_BITS-1:0] mplier_n;
	logic [WORD_BITS-1:0] quot_n;

	// stage register is free, or its item leaves this cycle
	assign up_ready = !valid_s1 || dn_ready;

	// step logic: acc is the product sum for multiply, the remainder for divide
	always_comb begin
		ge       = (up_acc >= up_mplier);
		diff     = up_acc - up_mplier;
		rem      = ge ? diff : up_acc;
		acc_n    = up_acc;
		mcand_n  = up_mcand;
		mplier_n = up_mplier;
		quot_n   = up_quot;
		case (up_ctrl.cmd)
			CMD_MUL: begin
				acc_n    = up_acc + (up_mplier[0] ? up_mcand : '0);
				mcand_n  = {up_mcand[MAG_BITS-2:0], 1'b0};
				mplier_n = {1'b0, up_mplier[MAG_BITS-1:1]};
			end
			CMD_DIV: begin
				acc_n  = {rem[MAG_BITS-2:0], 1'b0};
				quot_n = {up_quot[WORD_BITS-2:0], ge};
			end
			default: begin
				acc_n = up_acc;
			end
		endcase
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			ctrl_s1   <= up_ctrl;
			acc_s1    <= acc_n;
			mcand_s1  <= mcand_n;
			mplier_s1 <= mplier_n;
			quot_s1   <= quot_n;
		end
	end

	assign dn_valid  = valid_s1;
	assign dn_ctrl   = ctrl_s1;
	assign dn_acc    = acc_s1;
	assign dn_mcand  = mcand_s1;
	assign dn_mplier = mplier_s1;
	assign dn_quot   = quot_s1;

endmodule

// ===== rtl/core/sign_magnitude_mul_div_unit.sv =====
// Channel  | Dir | Fields                              | Transfer
// op       | in  | command, operand_a, operand_b       | valid && ready
// res      | out | result_sign, result_bits            | valid && ready
//
// One stage per multiply or divide step, WORD_BITS stages. res.valid is
// driven by the last stage register, so each item passes every stage
// register first. One operation per cycle is sustained while res is ready.
// Reset clears only the stage valid bits and the in-flight counter; no clearing pass.
// Each stage takes a new item when it is empty or its item moves on, so a
// stall on res fills bubbles first and backs up to op.ready without loss.
// Top level of the sign-magnitude multiply/divide unit.
// Depends on smmd_pkg, smmd_if, smmd_stage and the assertion macro header.
`timescale 1ns / 1ps
`include "sign_magnitude_mul_div_unit_macros.svh"

module sign_magnitude_mul_div_unit
	import smmd_pkg::*;
#(
	parameter int WORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	smmd_op_if.sink          op,
	smmd_res_if.source       res
);

	localparam int MAG_BITS = WORD_BITS - 1;
	localparam int CNT_BITS = $clog2(WORD_BITS + 1) + 1;

	logic [WORD_BITS:0]  v;
	logic [WORD_BITS:0]  rdy;
	ctrl_t               c      [WORD_BITS+1];
	logic [MAG_BITS-1:0] acc    [WORD_BITS+1];
	logic [MAG_BITS-1:0] mcand  [WORD_BITS+1];
	logic [MAG_BITS-1:0] mplier [WORD_BITS+1];
	logic [WORD_BITS-1:0] quot  [WORD_BITS+1];

	logic [CNT_BITS-1:0] cnt_q;

	// unpack operands into the first stage's inputs
	assign v[0]      = op.valid;
	assign c[0].cmd  = cmd_t'(op.command);
	assign c[0].sign = op.operand_a[WORD_BITS-1] ^ op.operand_b[WORD_BITS-1];
	assign mcand[0]  = op.operand_a[MAG_BITS-1:0];
	assign mplier[0] = op.operand_b[MAG_BITS-1:0];
	assign acc[0]    = (cmd_t'(op.command) == CMD_DIV) ? op.operand_a[MAG_BITS-1:0] : '0;
	assign quot[0]   = '0;

	assign op.ready = rdy[0];

	// one stage per step
	for (genvar k = 0; k < WORD_BITS; k++) begin : g_stage
		smmd_stage #(
			.WORD_BITS (WORD_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_valid  (v[k]),
			.up_ready  (rdy[k]),
			.up_ctrl   (c[k]),
			.up_acc    (acc[k]),
			.up_mcand  (mcand[k]),
			.up_mplier (mplier[k]),
			.up_quot   (quot[k]),
			.dn_valid  (v[k+1]),
			.dn_ready  (rdy[k+1]),
			.dn_ctrl   (c[k+1]),
			.dn_acc    (acc[k+1]),
			.dn_mcand  (mcand[k+1]),
			.dn_mplier (mplier[k+1]),
			.dn_quot   (quot[k+1])
		);
	end

	// result from the last stage register
	assign rdy[WORD_BITS]  = res.ready;
	assign res.valid       = v[WORD_BITS];
	assign res.result_sign = c[WORD_BITS].sign;
	assign res.result_bits = (c[WORD_BITS].cmd == CMD_MUL) ?
		{1'b0, acc[WORD_BITS]} : quot[WORD_BITS];

	// items in flight, for checking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({op.valid && op.ready, res.valid && res.ready})
				2'b10:   cnt_q <= cnt_q + CNT_BITS'(1);
				2'b01:   cnt_q <= cnt_q - CNT_BITS'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// assertions
	`SMMD_ASSERT(a_inflight_count, cnt_q == CNT_BITS'($countones(v[WORD_BITS:1])), "item lost or duplicated in pipeline")
	`SMMD_ASSERT(a_ready_when_empty, (v[WORD_BITS:1] == '0) |-> op.ready, "op not ready with empty pipeline")
	`SMMD_ASSERT(a_mul_top_zero, (res.valid && c[WORD_BITS].cmd == CMD_MUL) |-> !res.result_bits[WORD_BITS-1], "multiply result top bit set")
	`SMMD_ASSERT_NEXT(a_full_stall, (v[WORD_BITS:1] == '1) && !res.ready, !$fell(v[WORD_BITS]), "result dropped under stall")

endmodule
